/* sv/magp_pkg.sv */
// Shared types and constants for the mask atlas grid packer.
package magp_pkg;

    // Field widths of the transfer payloads
    localparam int SIZE_W     = 15;
    localparam int TILE_IDX_W = 6;
    localparam int OFF_W      = 14;
    localparam int EXT_W      = 15;

    // Tile store depth default and configuration defaults
    localparam int MAX_TILES_DEFAULT = 16;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;
    localparam logic [SIZE_W-1:0] LIMIT_RESET = SIZE_W'(4096);

    // Register word indexes
    localparam logic REG_ATLAS_LIMIT = 1'b0;

    // One requested tile size
    typedef struct packed {
        logic [SIZE_W-1:0] tile_size;
        logic              last_size;
    } tile_in_t;

    // Placement of one tile
    typedef struct packed {
        logic [TILE_IDX_W-1:0] tile_index;
        logic [TILE_IDX_W-1:0] atlas_number;
        logic [OFF_W-1:0]      x_offset;
        logic [OFF_W-1:0]      y_offset;
        logic [EXT_W-1:0]      atlas_width;
        logic [EXT_W-1:0]      atlas_height;
        logic                  last_tile;
    } tile_out_t;

    // Entry of the placement memory, indexed by tile
    typedef struct packed {
        logic [TILE_IDX_W-1:0] atlas_number;
        logic [OFF_W-1:0]      x_offset;
        logic [OFF_W-1:0]      y_offset;
        logic [EXT_W-1:0]      atlas_width;
        logic [EXT_W-1:0]      atlas_height;
    } place_t;

endpackage

/* sv/mask_atlas_grid_packer_core.sv */
// Top level of the mask atlas grid packer: tile store, packing sequencer, result stream.
//
// Input channel (s_valid/s_ready/s_data): one tile size per transfer. Sizes
// are written to the tile store, one per cycle; sizes beyond MAX_TILES are
// dropped. The transfer with last_size set closes the set and starts packing;
// s_ready stays low from then until the final result has been taken.
// Result channel (m_valid/m_ready/m_data): one transfer per loaded tile, in
// load order, last_tile set on the final one.
// Packing walks the tile store once per group to count members and once to
// place them, each entry read passing an issue and a compare state, and runs
// a 15-step shared divider once per group for the per-row count and twice per
// atlas. Each result is read from the placement memory, loaded into the result
// register and held there until m_ready is high.
// A stalled receiver simply holds the result register; nothing is lost.
// Reset empties the store, clears all placement flags and sets
// atlas_size_limit to 4096; it needs no clearing pass. atlas_size_limit is
// written through the APB port at byte address 0; the user must write it only
// while the block is idle, which the block itself does not enforce.
module mask_atlas_grid_packer_core #(
    parameter int MAX_TILES = magp_pkg::MAX_TILES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // size input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  magp_pkg::tile_in_t                  s_data,
    // placement output
    output logic                                m_valid,
    input  logic                                m_ready,
    output magp_pkg::tile_out_t                 m_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [magp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [magp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [magp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import magp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_TILES + 1);
    localparam int IDX_W  = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int STEP_W = $clog2(SIZE_W);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TILES);

    typedef enum logic [3:0] {
        S_LOAD, S_LEAD, S_LEAD_RD, S_DIV, S_PERROW, S_CNT_ISSUE, S_CNT_CMP,
        S_ATLAS, S_ROWS, S_COLS, S_EXT, S_PL_ISSUE, S_PL_CMP,
        S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
    } state_t;

    // Storage
    logic [SIZE_W-1:0] size_mem [MAX_TILES];
    place_t            res_mem  [MAX_TILES];
    logic [SIZE_W-1:0] size_rd_reg;
    place_t            res_rd_reg;
    logic [MAX_TILES-1:0] placed_reg;

    // Sequencer state
    state_t            state_reg;
    state_t            div_ret_reg;
    logic [SIZE_W-1:0] limit_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  lead_reg;
    logic [CNT_W-1:0]  scan_reg;
    logic [CNT_W-1:0]  group_n_reg;
    logic [CNT_W-1:0]  rest_reg;
    logic [CNT_W-1:0]  held_reg;
    logic [CNT_W-1:0]  rows_reg;
    logic [CNT_W-1:0]  cols_reg;
    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  out_idx_reg;
    logic [IDX_W-1:0]  atlas_reg;
    logic [SIZE_W-1:0] grp_raw_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] per_row_reg;
    logic [OFF_W-1:0]  x_reg;
    logic [OFF_W-1:0]  y_reg;
    logic [EXT_W-1:0]  width_reg;
    logic [EXT_W-1:0]  height_reg;
    logic              m_valid_reg;
    tile_out_t         m_data_reg;

    // Shared restoring divider
    logic [SIZE_W-1:0] div_num_reg;
    logic [SIZE_W-1:0] div_den_reg;
    logic [SIZE_W-1:0] div_rem_reg;
    logic [SIZE_W-1:0] div_quo_reg;
    logic [STEP_W-1:0] div_step_reg;
    logic [SIZE_W:0]   div_shift;
    logic [SIZE_W:0]   div_diff;
    logic              div_take;
    logic [SIZE_W-1:0] div_rem_next;
    logic [SIZE_W-1:0] div_quo_next;

    // Helpers
    logic              s_xfer;
    logic              cfg_wr;
    logic [CNT_W-1:0]  size_rd_addr;
    logic [SIZE_W-1:0] size_eff;
    logic [2*CNT_W-1:0] grid_cap;
    logic [CNT_W-1:0]  held_c;
    logic [CNT_W-1:0]  quo_plus1;
    logic [CNT_W+SIZE_W-1:0] ext_w_full;
    logic [CNT_W+SIZE_W-1:0] ext_h_full;
    logic              match;
    place_t            place_entry;

    assign s_xfer  = s_valid && s_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_ATLAS_LIMIT) ? APB_DATA_W'(limit_reg) : '0;
    assign s_ready = (state_reg == S_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Divider step: shift in one numerator bit, subtract when it fits
    assign div_shift    = {div_rem_reg, div_num_reg[SIZE_W-1]};
    assign div_diff     = div_shift - {1'b0, div_den_reg};
    assign div_take     = (div_shift >= {1'b0, div_den_reg});
    assign div_rem_next = div_take ? div_diff[SIZE_W-1:0] : div_shift[SIZE_W-1:0];
    assign div_quo_next = {div_quo_reg[SIZE_W-2:0], div_take};

    // Atlas sizing: a zero size places as one, tiles held bounded by per_row squared
    assign size_eff   = (size_rd_reg == '0) ? SIZE_W'(1) : size_rd_reg;
    assign grid_cap   = per_row_reg[CNT_W-1:0] * per_row_reg[CNT_W-1:0];
    assign held_c     = (per_row_reg > SIZE_W'(rest_reg)) ? rest_reg :
                        ((grid_cap < (2*CNT_W)'(rest_reg)) ? grid_cap[CNT_W-1:0]
                                                            : rest_reg);
    assign quo_plus1  = div_quo_reg[CNT_W-1:0] + CNT_W'(1);
    assign ext_w_full = cols_reg * size_reg;
    assign ext_h_full = rows_reg * size_reg;
    assign match      = (size_rd_reg == grp_raw_reg);
    assign size_rd_addr = (state_reg == S_LEAD) ? lead_reg : scan_reg;

    always_comb begin
        place_entry.atlas_number = TILE_IDX_W'(atlas_reg);
        place_entry.x_offset     = x_reg;
        place_entry.y_offset     = y_reg;
        place_entry.atlas_width  = width_reg;
        place_entry.atlas_height = height_reg;
    end

    // Tile store: write on input transfer, read one entry a cycle
    always_ff @(posedge aclk) begin
        if (s_xfer && (count_reg < MAX_CNT)) begin
            size_mem[count_reg[IDX_W-1:0]] <= s_data.tile_size;
        end
        size_rd_reg <= size_mem[size_rd_addr[IDX_W-1:0]];
    end

    // Placement memory: written while placing, read in load order while emitting
    always_ff @(posedge aclk) begin
        if ((state_reg == S_PL_CMP) && match) begin
            res_mem[scan_reg[IDX_W-1:0]] <= place_entry;
        end
        res_rd_reg <= res_mem[out_idx_reg[IDX_W-1:0]];
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr && (paddr[2] == REG_ATLAS_LIMIT)) begin
            limit_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // Packing sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            placed_reg  <= '0;
            atlas_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (s_xfer) begin
                        if (count_reg < MAX_CNT) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (s_data.last_size) begin
                            placed_reg <= '0;
                            atlas_reg  <= '0;
                            lead_reg   <= '0;
                            state_reg  <= S_LEAD;
                        end
                    end
                end
                // Find the next unplaced tile to lead a group
                S_LEAD: begin
                    if (lead_reg == count_reg) begin
                        out_idx_reg <= '0;
                        state_reg   <= S_EMIT_RD;
                    end else if (placed_reg[lead_reg[IDX_W-1:0]]) begin
                        lead_reg <= lead_reg + CNT_W'(1);
                    end else begin
                        state_reg <= S_LEAD_RD;
                    end
                end
                S_LEAD_RD: begin
                    grp_raw_reg  <= size_rd_reg;
                    size_reg     <= size_eff;
                    div_num_reg  <= limit_reg;
                    div_den_reg  <= size_eff;
                    div_rem_reg  <= '0;
                    div_step_reg <= '0;
                    div_ret_reg  <= S_PERROW;
                    state_reg    <= S_DIV;
                end
                S_DIV: begin
                    div_rem_reg  <= div_rem_next;
                    div_quo_reg  <= div_quo_next;
                    div_num_reg  <= {div_num_reg[SIZE_W-2:0], 1'b0};
                    div_step_reg <= div_step_reg + STEP_W'(1);
                    if (div_step_reg == STEP_W'(SIZE_W - 1)) begin
                        state_reg <= div_ret_reg;
                    end
                end
                S_PERROW: begin
                    per_row_reg <= (div_quo_reg == '0) ? SIZE_W'(1) : div_quo_reg;
                    scan_reg    <= lead_reg;
                    group_n_reg <= '0;
                    state_reg   <= S_CNT_ISSUE;
                end
                // Count the members of the group
                S_CNT_ISSUE: begin
                    if (scan_reg == count_reg) begin
                        rest_reg  <= group_n_reg;
                        scan_reg  <= lead_reg;
                        state_reg <= S_ATLAS;
                    end else begin
                        state_reg <= S_CNT_CMP;
                    end
                end
                S_CNT_CMP: begin
                    if (match) begin
                        group_n_reg <= group_n_reg + CNT_W'(1);
                    end
                    scan_reg  <= scan_reg + CNT_W'(1);
                    state_reg <= S_CNT_ISSUE;
                end
                // Open an atlas: rows = ceil(held / per_row)
                S_ATLAS: begin
                    if (rest_reg == '0) begin
                        lead_reg  <= lead_reg + CNT_W'(1);
                        state_reg <= S_LEAD;
                    end else begin
                        held_reg     <= held_c;
                        div_num_reg  <= SIZE_W'(held_c - CNT_W'(1));
                        div_den_reg  <= per_row_reg;
                        div_rem_reg  <= '0;
                        div_step_reg <= '0;
                        div_ret_reg  <= S_ROWS;
                        state_reg    <= S_DIV;
                    end
                end
                // cols = ceil(held / rows)
                S_ROWS: begin
                    rows_reg     <= quo_plus1;
                    div_num_reg  <= SIZE_W'(held_reg - CNT_W'(1));
                    div_den_reg  <= SIZE_W'(quo_plus1);
                    div_rem_reg  <= '0;
                    div_step_reg <= '0;
                    div_ret_reg  <= S_COLS;
                    state_reg    <= S_DIV;
                end
                S_COLS: begin
                    cols_reg  <= quo_plus1;
                    state_reg <= S_EXT;
                end
                S_EXT: begin
                    width_reg  <= ext_w_full[EXT_W-1:0];
                    height_reg <= ext_h_full[EXT_W-1:0];
                    left_reg   <= held_reg;
                    col_reg    <= '0;
                    x_reg      <= '0;
                    y_reg      <= '0;
                    state_reg  <= S_PL_ISSUE;
                end
                // Place group members in load order
                S_PL_ISSUE: begin
                    state_reg <= S_PL_CMP;
                end
                S_PL_CMP: begin
                    scan_reg <= scan_reg + CNT_W'(1);
                    if (match) begin
                        placed_reg[scan_reg[IDX_W-1:0]] <= 1'b1;
                        rest_reg <= rest_reg - CNT_W'(1);
                        left_reg <= left_reg - CNT_W'(1);
                        if (col_reg == cols_reg - CNT_W'(1)) begin
                            col_reg <= '0;
                            x_reg   <= '0;
                            y_reg   <= y_reg + size_reg[OFF_W-1:0];
                        end else begin
                            col_reg <= col_reg + CNT_W'(1);
                            x_reg   <= x_reg + size_reg[OFF_W-1:0];
                        end
                        if (left_reg == CNT_W'(1)) begin
                            atlas_reg <= atlas_reg + IDX_W'(1);
                            state_reg <= S_ATLAS;
                        end else begin
                            state_reg <= S_PL_ISSUE;
                        end
                    end else begin
                        state_reg <= S_PL_ISSUE;
                    end
                end
                // Stream results in load order
                S_EMIT_RD: begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    m_data_reg.tile_index   <= TILE_IDX_W'(out_idx_reg);
                    m_data_reg.atlas_number <= res_rd_reg.atlas_number;
                    m_data_reg.x_offset     <= res_rd_reg.x_offset;
                    m_data_reg.y_offset     <= res_rd_reg.y_offset;
                    m_data_reg.atlas_width  <= res_rd_reg.atlas_width;
                    m_data_reg.atlas_height <= res_rd_reg.atlas_height;
                    m_data_reg.last_tile    <= (out_idx_reg + CNT_W'(1) == count_reg);
                    m_valid_reg             <= 1'b1;
                    state_reg               <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (out_idx_reg + CNT_W'(1) == count_reg) begin
                            count_reg  <= '0;
                            placed_reg <= '0;
                            atlas_reg  <= '0;
                            state_reg  <= S_LOAD;
                        end else begin
                            out_idx_reg <= out_idx_reg + CNT_W'(1);
                            state_reg   <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // Input and output sides are never open together
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    // A closing transfer stops further input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_size) |=> !s_ready)
        else $error("input still open after closing transfer");

    // The final result empties the store and reopens the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_tile) |=> (s_ready && count_reg == '0))
        else $error("store not emptied after final result");

    // Fill count never passes the store depth
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= MAX_CNT)
        else $error("tile count beyond store depth");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the mask atlas grid packer core.
module tb;
    import magp_pkg::*;

    localparam int TILE_SLOTS    = 16;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = APB_ADDR_W'({REG_ATLAS_LIMIT, 2'b00});

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    tile_in_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    tile_out_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Packer state as the testbench sees it
    logic [SIZE_W-1:0] size_list [TILE_SLOTS];
    int unsigned       loaded     = 0;
    logic [SIZE_W-1:0] limit_reg  = LIMIT_RESET;
    tile_out_t         placements_due [$];

    // Run bookkeeping
    int unsigned fail_count    = 0;
    int unsigned sizes_sent    = 0;
    int unsigned sets_closed   = 0;
    int unsigned tiles_checked = 0;
    int unsigned limit_writes  = 0;
    int unsigned cycle_count   = 0;

    // Idling controls
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int unsigned hold_seq  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    mask_atlas_grid_packer_core #(.MAX_TILES(TILE_SLOTS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 aclk = ~aclk;

    // Group equal sizes, cut each group into atlases and queue one placement per tile
    function automatic void pack_tile_set();
        bit              taken   [TILE_SLOTS];
        int unsigned     members [TILE_SLOTS];
        tile_out_t       plan    [TILE_SLOTS];
        int unsigned     atlas, lead, i, j, n, base, held, rows, cols, per_row, side, t;
        longint unsigned tiles_cap;
        atlas = 0;
        for (i = 0; i < TILE_SLOTS; i++) begin
            taken[i] = 1'b0;
            plan[i]  = '0;
        end
        for (lead = 0; lead < loaded; lead++) begin
            if (taken[lead])
                continue;
            // a zero size groups with zeros but is laid out as one pixel
            side    = (size_list[lead] == '0) ? 1 : 32'(size_list[lead]);
            per_row = limit_reg / side;
            if (per_row < 1)
                per_row = 1;
            tiles_cap = longint'(per_row) * per_row;
            n = 0;
            for (i = lead; i < loaded; i++) begin
                if (!taken[i] && size_list[i] == size_list[lead]) begin
                    taken[i]   = 1'b1;
                    members[n] = i;
                    n++;
                end
            end
            base = 0;
            while (base < n) begin
                held = ((n - base) < tiles_cap) ? (n - base) : int'(tiles_cap);
                rows = (held + per_row - 1) / per_row;
                cols = (held + rows - 1) / rows;
                for (j = 0; j < held; j++) begin
                    t = members[base + j];
                    plan[t].atlas_number = TILE_IDX_W'(atlas);
                    plan[t].x_offset     = OFF_W'((j % cols) * side);
                    plan[t].y_offset     = OFF_W'((j / cols) * side);
                    plan[t].atlas_width  = EXT_W'(cols * side);
                    plan[t].atlas_height = EXT_W'(rows * side);
                end
                atlas++;
                base += held;
            end
        end
        for (i = 0; i < loaded; i++) begin
            plan[i].tile_index = TILE_IDX_W'(i);
            plan[i].last_tile  = (i + 1 == loaded);
            placements_due = {placements_due, plan[i]};
        end
    endfunction

    // Store an accepted size; the closing size packs the set and empties the store
    function automatic void take_size(logic [SIZE_W-1:0] size, bit last);
        if (loaded < TILE_SLOTS) begin
            size_list[loaded] = size;
            loaded++;
        end
        if (last) begin
            pack_tile_set();
            loaded = 0;
            sets_closed++;
        end
    endfunction

    // Offer one size, with random idle cycles ahead of it, and hold until the transfer
    task automatic send_size(logic [SIZE_W-1:0] size, bit last);
        if (!tx_steady) begin
            while ($urandom_range(0, 99) < 26) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= '{tile_size: size, last_size: last};
        do @(posedge aclk); while (!s_ready);
        take_size(size, last);
        sizes_sent++;
    endtask

    // Drop valid and wait until every queued placement has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (placements_due.size() != 0)
            @(posedge aclk);
    endtask

    // Write the atlas size limit on an idle block, then read it back
    task automatic write_limit(int unsigned value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        limit_reg = SIZE_W'(value);
        limit_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[SIZE_W-1:0] !== limit_reg) begin
            fail_count++;
            $display("%0t: limit readback mismatch, expected %0d, got %0d",
                     $time, limit_reg, prdata[SIZE_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly small sizes, with zero, 16384 and values up to 16384 mixed in
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'(16384);
            2, 3:    return SIZE_W'($urandom_range(0, 16384));
            default: return SIZE_W'($urandom_range(1, 1024));
        endcase
    endfunction

    // Send one closed set of n sizes drawn mostly from a small pool, so groups form
    task automatic send_random_set(int unsigned n);
        logic [SIZE_W-1:0] pool [3];
        int unsigned       i;
        for (i = 0; i < 3; i++)
            pool[i] = pick_size();
        for (i = 1; i <= n; i++) begin
            if ($urandom_range(0, 4) == 0)
                send_size(pick_size(), i == n);
            else
                send_size(pool[$urandom_range(0, 2)], i == n);
        end
    endtask

    task automatic test_size_extremes();
        // zero, 16384 and the top of the size range, with repeats to form groups
        send_size(SIZE_W'(0), 1'b0);
        send_size(SIZE_W'(512), 1'b0);
        send_size(SIZE_W'(16384), 1'b0);
        send_size(SIZE_W'(512), 1'b0);
        send_size(SIZE_W'(0), 1'b0);
        send_size(SIZE_W'(32767), 1'b1);
        // a set of one
        send_size(SIZE_W'(1), 1'b1);
    endtask

    task automatic test_limit_extremes();
        // zero limit: one tile per atlas
        write_limit(0);
        repeat (3) send_size(SIZE_W'(7), 1'b0);
        send_size(SIZE_W'(7), 1'b1);
        // widest limit: offsets wrap at the field width
        write_limit(32767);
        send_size(SIZE_W'(10000), 1'b0);
        send_size(SIZE_W'(10000), 1'b0);
        send_size(SIZE_W'(10000), 1'b1);
        write_limit(1);
        send_size(SIZE_W'(1), 1'b0);
        send_size(SIZE_W'(2), 1'b1);
        write_limit(16384);
        send_size(SIZE_W'(16384), 1'b0);
        send_size(SIZE_W'(8192), 1'b0);
        send_size(SIZE_W'(8192), 1'b0);
        send_size(SIZE_W'(8192), 1'b1);
    endtask

    task automatic test_store_overflow();
        int unsigned i;
        // two sizes past a full store: dropped, but the last one still closes
        write_limit(128);
        for (i = 1; i <= TILE_SLOTS + 2; i++)
            send_size((i % 3 == 0) ? SIZE_W'(32) : SIZE_W'(64), i == TILE_SLOTS + 2);
    endtask

    task automatic test_backpressure();
        // stall the receiver and keep offering sets until the input stalls too
        write_limit(4096);
        tx_steady = 1'b1;
        hold_seq++;
        repeat (3) send_random_set(4);
        tx_steady = 1'b0;
        // pause the sender until every placement is out
        wait_drained();
    endtask

    task automatic test_random_sets();
        int unsigned phase, target, n;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       write_limit(4096);
                1:       write_limit($urandom_range(1, 16384));
                2:       write_limit(16384);
                default: write_limit($urandom_range(1, 512));
            endcase
            // one phase runs with no idling on either side
            tx_steady = (phase == 2);
            rx_steady = (phase == 2);
            target = sizes_sent + 15;
            while (sizes_sent < target) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(TILE_SLOTS + 1, TILE_SLOTS + 4)
                                                : $urandom_range(1, 8);
                send_random_set(n);
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver: random stalls, a long hold-off on request, or always ready
    always @(posedge aclk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (rx_steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 26);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Compare each placement transfer with the oldest expected one
    always @(posedge aclk) begin
        tile_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (placements_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected placement, expected none, got tile %0d",
                         $time, m_data.tile_index);
            end else begin
                want = placements_due.pop_front();
                check_field("tile_index", 32'(want.tile_index), 32'(m_data.tile_index));
                check_field("atlas_number", 32'(want.atlas_number),
                            32'(m_data.atlas_number));
                check_field("x_offset", 32'(want.x_offset), 32'(m_data.x_offset));
                check_field("y_offset", 32'(want.y_offset), 32'(m_data.y_offset));
                check_field("atlas_width", 32'(want.atlas_width), 32'(m_data.atlas_width));
                check_field("atlas_height", 32'(want.atlas_height),
                            32'(m_data.atlas_height));
                check_field("last_tile", 32'(want.last_tile), 32'(m_data.last_tile));
                tiles_checked++;
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_size_extremes();
        test_limit_extremes();
        test_store_overflow();
        test_backpressure();
        test_random_sets();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d tile sizes in %0d sets; checked %0d placements", sizes_sent,
                 sets_closed, tiles_checked);
        $display("Wrote the atlas limit %0d times; %0d mismatches", limit_writes, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
